[src/hbw_pkg.sv]
`timescale 1ns / 1ps

package hbw_pkg;

    // request codes carried in req_type
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_REGISTER = 3'd1;
    localparam logic [2:0] REQ_CHECKIN  = 3'd2;
    localparam logic [2:0] REQ_CHECK    = 3'd3;
    localparam logic [2:0] REQ_WD_TICK  = 3'd4;

    // register indexes on the configuration port
    localparam logic REG_DEADLINE = 1'b0;
    localparam logic REG_RELOAD   = 1'b1;

    localparam logic [31:0] DEADLINE_RESET = 32'd1000;
    localparam logic [11:0] RELOAD_RESET   = 12'd1875;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] slot;
    } t_request;

    typedef struct packed {
        logic [2:0] assigned_slot;
        logic       register_refused;
        logic       checkin_accepted;
        logic [7:0] stalled_mask;
        logic       watchdog_fed;
        logic       reset_request;
    } t_result;

endpackage

[src/hbw_slot_ram.sv]
`timescale 1ns / 1ps

module hbw_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/hbw_elapsed_cmp.sv]
`timescale 1ns / 1ps

module hbw_elapsed_cmp (
    input  logic [31:0] i_tick_now,
    input  logic [31:0] i_stamp,
    input  logic [31:0] i_deadline,
    output logic        o_stalled
);

    logic [31:0] elapsed;

    // elapsed time wraps modulo 2^32
    assign elapsed   = i_tick_now - i_stamp;
    assign o_stalled = elapsed > i_deadline;

endmodule

[src/multi_task_heartbeat_watchdog_core.sv]
`timescale 1ns / 1ps
// Heartbeat watchdog for up to MAX_SLOTS tasks.
// Request channel (i_in_valid / o_in_stall / i_in_data) carries one request
// per beat: tick, register, check-in, health check or watchdog tick. Every
// request gives exactly one result beat on o_out_valid / i_out_stall /
// o_out_data; reset_request is carried in every result.
// Tick, register, check-in, watchdog tick and unknown codes finish at the
// accepting edge: the result is on the outputs in the next cycle, and one
// such request per cycle is taken while results drain.
// A health check walks the registered slots through the single stamp memory
// read port and one elapsed-time comparator, each slot passing through a read
// state and then a compare state; the result is given once the last registered
// slot is compared (at once when none). The request side stalls meanwhile.
// While a result beat is stalled the output register holds it and no new
// request is taken. Configuration is an APB-style port, deadline at 0x0 and
// reload value at 0x4, always ready.
// Reset (synchronous, active low) clears the tick count, empties the slot
// table, loads the watchdog counter with 1875 and clears the reset request;
// stamp memory is not cleared, a slot is stamped when registered.
module multi_task_heartbeat_watchdog_core #(
    parameter int MAX_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hbw_pkg::t_request i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hbw_pkg::t_result  o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} t_state;

    t_state              r_state, n_state;
    logic [31:0]         r_deadline, r_tick, n_tick;
    logic [11:0]         r_reload, r_wd_count, n_wd_count;
    logic [CNT_W-1:0]    r_used, n_used;
    logic                r_reset_latched, n_reset_latched;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [7:0]          r_mask, n_mask;
    logic                r_out_valid, n_out_valid;
    hbw_pkg::t_result    r_out, n_out;
    logic                r_any_stalled;

    logic                accept, cfg_wr;
    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [31:0]         ram_rdata;
    logic                slot_stalled;
    logic [7:0]          slot_bit;
    logic [11:0]         wd_dec;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == hbw_pkg::REG_RELOAD) ? {20'd0, r_reload} : r_deadline;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    hbw_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_tick),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    hbw_elapsed_cmp u_cmp (
        .i_tick_now (r_tick),
        .i_stamp    (ram_rdata),
        .i_deadline (r_deadline),
        .o_stalled  (slot_stalled)
    );

    assign ram_re   = (r_state == S_READ);
    assign slot_bit = (6'(r_idx) < 6'd8) ? (8'd1 << r_idx) : 8'd0;
    assign wd_dec   = (r_wd_count != 12'd0) ? r_wd_count - 12'd1 : 12'd0;

    always_comb begin
        n_state         = r_state;
        n_tick          = r_tick;
        n_used          = r_used;
        n_wd_count      = r_wd_count;
        n_reset_latched = r_reset_latched;
        n_idx           = r_idx;
        n_mask          = r_mask;
        n_out           = r_out;
        n_out_valid     = r_out_valid && i_out_stall;
        ram_we          = 1'b0;
        ram_waddr       = SLOT_W'(r_used);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    case (i_in_data.req_type)
                        hbw_pkg::REQ_TICK: begin
                            n_tick = r_tick + 32'd1;
                        end
                        hbw_pkg::REQ_REGISTER: begin
                            if (6'(r_used) >= 6'(MAX_SLOTS)) begin
                                n_out.register_refused = 1'b1;
                            end else begin
                                ram_we              = 1'b1;
                                n_out.assigned_slot = 3'(r_used);
                                n_used              = r_used + CNT_W'(1);
                            end
                        end
                        hbw_pkg::REQ_CHECKIN: begin
                            if (6'(i_in_data.slot) < 6'(r_used)) begin
                                ram_we                 = 1'b1;
                                ram_waddr              = SLOT_W'(i_in_data.slot);
                                n_out.checkin_accepted = 1'b1;
                            end
                        end
                        hbw_pkg::REQ_CHECK: begin
                            if (r_used == '0) begin
                                n_wd_count         = r_reload;
                                n_out.watchdog_fed = 1'b1;
                            end else begin
                                // result is held back until the walk ends
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_mask      = '0;
                                n_state     = S_READ;
                            end
                        end
                        hbw_pkg::REQ_WD_TICK: begin
                            n_wd_count = wd_dec;
                            if (wd_dec == 12'd0) begin
                                n_reset_latched = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.reset_request = n_reset_latched;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (slot_stalled) begin
                    n_mask = r_mask | slot_bit;
                end
                if (CNT_W'(r_idx) + CNT_W'(1) == r_used) begin
                    // stalled slots beyond bit 7 still block the feed
                    n_out               = '0;
                    n_out.stalled_mask  = n_mask;
                    if (!slot_stalled && !r_any_stalled) begin
                        n_wd_count         = r_reload;
                        n_out.watchdog_fed = 1'b1;
                    end
                    n_out.reset_request = r_reset_latched;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_deadline      <= hbw_pkg::DEADLINE_RESET;
            r_reload        <= hbw_pkg::RELOAD_RESET;
            r_tick          <= '0;
            r_used          <= '0;
            r_wd_count      <= hbw_pkg::RELOAD_RESET;
            r_reset_latched <= 1'b0;
            r_out_valid     <= 1'b0;
            r_any_stalled   <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_tick          <= n_tick;
            r_used          <= n_used;
            r_wd_count      <= n_wd_count;
            r_reset_latched <= n_reset_latched;
            r_out_valid     <= n_out_valid;
            if (r_state == S_IDLE) begin
                r_any_stalled <= 1'b0;
            end else if (r_state == S_CMP && slot_stalled) begin
                r_any_stalled <= 1'b1;
            end
            if (cfg_wr) begin
                if (paddr[2] == hbw_pkg::REG_RELOAD) begin
                    r_reload <= pwdata[11:0];
                end else begin
                    r_deadline <= pwdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        6'(r_used) <= 6'(MAX_SLOTS))
        else $error("slot table count beyond capacity");

    a_reset_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_reset_latched))
        else $error("reset request dropped without reset");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CNT_W'(r_idx) < r_used))
        else $error("check walk outside registered slots");

    a_fed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.watchdog_fed) |-> (r_out.stalled_mask == 8'd0))
        else $error("watchdog fed with a stalled slot");

endmodule

[dv/tb_multi_task_heartbeat_watchdog_core.sv]
`timescale 1ns / 1ps

module tb_multi_task_heartbeat_watchdog_core;

    localparam int          NUM_SLOTS     = 8;
    localparam int          ITEMS_PER_RUN = 500;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 24;
    localparam logic [31:0] DEADLINE_MAX  = 32'hFFFF_FFFF;
    localparam logic [11:0] RELOAD_MAX    = 12'd4095;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    hbw_pkg::t_request i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    hbw_pkg::t_result  o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int cycle_count     = 0;
    int config_writes   = 0;

    multi_task_heartbeat_watchdog_core #(.MAX_SLOTS(NUM_SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predicts each result from its own copy of the slot table and counters
    class heartbeat_scoreboard;
        logic [31:0]      deadline;
        logic [11:0]      reload;
        logic [31:0]      tick_now;
        logic [31:0]      stamp [NUM_SLOTS];
        logic [3:0]       used_slots;
        logic [11:0]      wd_count;
        logic             reset_latched;
        hbw_pkg::t_result pending_results[$];
        int               errors;
        int               requests;
        int               results;
        int               stalled_checks;
        int               feeds;

        function new();
            deadline      = hbw_pkg::DEADLINE_RESET;
            reload        = hbw_pkg::RELOAD_RESET;
            tick_now      = '0;
            used_slots    = '0;
            wd_count      = hbw_pkg::RELOAD_RESET;
            reset_latched = 1'b0;
            foreach (stamp[i]) stamp[i] = '0;
            errors         = 0;
            requests       = 0;
            results        = 0;
            stalled_checks = 0;
            feeds          = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == hbw_pkg::REG_DEADLINE)
                deadline = value;
            else
                reload = value[11:0];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", results, msg);
            errors++;
        endtask

        function void note_request(hbw_pkg::t_request req);
            hbw_pkg::t_result want;
            logic             healthy;
            want = '0;
            requests++;
            case (req.req_type)
                hbw_pkg::REQ_TICK: begin
                    tick_now = tick_now + 32'd1;
                end
                hbw_pkg::REQ_REGISTER: begin
                    if (used_slots >= NUM_SLOTS) begin
                        want.register_refused = 1'b1;
                    end else begin
                        stamp[used_slots[2:0]] = tick_now;
                        want.assigned_slot     = used_slots[2:0];
                        used_slots             = used_slots + 4'd1;
                    end
                end
                hbw_pkg::REQ_CHECKIN: begin
                    if ({1'b0, req.slot} < used_slots) begin
                        stamp[req.slot]       = tick_now;
                        want.checkin_accepted = 1'b1;
                    end
                end
                hbw_pkg::REQ_CHECK: begin
                    healthy = 1'b1;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (i < used_slots && (tick_now - stamp[i]) > deadline) begin
                            healthy              = 1'b0;
                            want.stalled_mask[i] = 1'b1;
                        end
                    end
                    if (healthy) begin
                        wd_count          = reload;
                        want.watchdog_fed = 1'b1;
                        feeds++;
                    end else begin
                        stalled_checks++;
                    end
                end
                hbw_pkg::REQ_WD_TICK: begin
                    if (wd_count != 12'd0)
                        wd_count = wd_count - 12'd1;
                    if (wd_count == 12'd0)
                        reset_latched = 1'b1;
                end
                default: ;
            endcase
            want.reset_request = reset_latched;
            pending_results.push_back(want);
        endfunction

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_result(hbw_pkg::t_result got);
            hbw_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result beat 0x%0h", got));
            end else begin
                want = pending_results.pop_front();
                compare_field("assigned_slot", 8'(got.assigned_slot),
                              8'(want.assigned_slot));
                compare_field("register_refused", 8'(got.register_refused),
                              8'(want.register_refused));
                compare_field("checkin_accepted", 8'(got.checkin_accepted),
                              8'(want.checkin_accepted));
                compare_field("stalled_mask", got.stalled_mask, want.stalled_mask);
                compare_field("watchdog_fed", 8'(got.watchdog_fed),
                              8'(want.watchdog_fed));
                compare_field("reset_request", 8'(got.reset_request),
                              8'(want.reset_request));
            end
            results++;
        endtask
    endclass

    heartbeat_scoreboard sb = new();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge i_clk) i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    task send_request(logic [2:0] req_type, logic [2:0] slot);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{req_type: req_type, slot: slot};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request('{req_type: req_type, slot: slot});
    endtask

    // sender goes quiet until every outstanding result beat has come back
    task drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task write_register(logic idx, logic [31:0] value);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        config_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task send_random_request();
        int unsigned roll;
        logic [2:0]  slot;
        roll = $urandom_range(0, 99);
        slot = $urandom_range(0, 7);
        if (roll < 40)
            send_request(hbw_pkg::REQ_TICK, slot);
        else if (roll < 65)
            send_request(hbw_pkg::REQ_CHECKIN, slot);
        else if (roll < 80)
            send_request(hbw_pkg::REQ_CHECK, slot);
        else if (roll < 90)
            send_request(hbw_pkg::REQ_WD_TICK, slot);
        else if (roll < 96)
            send_request(hbw_pkg::REQ_REGISTER, slot);
        else
            send_request(hbw_pkg::REQ_WD_TICK + 3'($urandom_range(1, 3)), slot);
    endtask

    initial begin
        int pause_at;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unregistered slot and unknown codes first
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        send_request(hbw_pkg::REQ_CHECKIN, 3'd7);
        send_request(hbw_pkg::REQ_WD_TICK + 3'd1, 3'd0);
        send_request(hbw_pkg::REQ_WD_TICK + 3'd2, 3'd5);
        send_request(hbw_pkg::REQ_WD_TICK + 3'd3, 3'd7);
        send_request(hbw_pkg::REQ_REGISTER, 3'd0);
        send_request(hbw_pkg::REQ_TICK, 3'd0);
        send_request(hbw_pkg::REQ_REGISTER, 3'd0);
        send_request(hbw_pkg::REQ_CHECKIN, 3'd1);
        send_request(hbw_pkg::REQ_CHECKIN, 3'd2);
        send_request(hbw_pkg::REQ_WD_TICK, 3'd0);

        // zero deadline: any slot not stamped this tick is stalled
        write_register(hbw_pkg::REG_DEADLINE, 32'd0);
        send_request(hbw_pkg::REQ_TICK, 3'd0);
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        send_request(hbw_pkg::REQ_CHECKIN, 3'd0);
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        for (int i = 0; i < NUM_SLOTS - 2; i++)
            send_request(hbw_pkg::REQ_REGISTER, 3'(i));
        send_request(hbw_pkg::REQ_REGISTER, 3'd7);

        // largest deadline never stalls
        write_register(hbw_pkg::REG_DEADLINE, DEADLINE_MAX);
        send_request(hbw_pkg::REQ_TICK, 3'd0);
        send_request(hbw_pkg::REQ_CHECK, 3'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_register(hbw_pkg::REG_DEADLINE, 32'd20);
                    write_register(hbw_pkg::REG_RELOAD,
                                   {20'($urandom), hbw_pkg::RELOAD_RESET});
                end
                1: begin
                    write_register(hbw_pkg::REG_DEADLINE, 32'd0);
                    write_register(hbw_pkg::REG_RELOAD, {20'($urandom), RELOAD_MAX});
                end
                2: begin
                    write_register(hbw_pkg::REG_DEADLINE, 32'($urandom_range(5, 60)));
                    write_register(hbw_pkg::REG_RELOAD, 32'($urandom_range(2, 4094)));
                end
                default: begin
                    write_register(hbw_pkg::REG_DEADLINE, DEADLINE_MAX);
                    write_register(hbw_pkg::REG_RELOAD, 32'd1);
                end
            endcase
            sender_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 29 : 0;
            stall_pct       = (phase == 2) ? 51 : (phase == 3) ? 29 : 0;
            pause_at = $urandom_range(50, ITEMS_PER_RUN - 50);
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                if (n == pause_at)
                    drain();
                send_random_request();
            end
        end

        // zero reload latches on the next watchdog tick; feeds keep it latched
        write_register(hbw_pkg::REG_RELOAD, 32'd0);
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        send_request(hbw_pkg::REQ_WD_TICK, 3'd0);
        send_request(hbw_pkg::REQ_WD_TICK, 3'd0);
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        write_register(hbw_pkg::REG_RELOAD, {20'($urandom), RELOAD_MAX});
        send_request(hbw_pkg::REQ_CHECK, 3'd0);
        send_request(hbw_pkg::REQ_WD_TICK, 3'd0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests and %0d result beats over %0d register writes",
                 sb.requests, sb.results, config_writes);
        $display("%0d health checks fed the watchdog, %0d found stalled slots",
                 sb.feeds, sb.stalled_checks);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
